// ===== src/upd_pkg.sv =====
// Shared types, character codes and hex helpers for the URL percent decoder.
// Used by every module of the decoder; depends on nothing.
package upd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam int GROUP_MAX = 3;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  typedef struct packed {
    logic [GROUP_MAX-1:0][7:0] data;
    logic [1:0]                cnt;
    logic                      last;
  } group_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    if (c <= 8'h39) begin
      v = c[3:0];
    end else begin
      v = 4'(c[3:0] + 4'd9);
    end
    return v;
  endfunction

endpackage

// ===== src/url_percent_decoder.sv =====
// Top level of the streaming URL percent decoder.
// Instantiates upd_front, upd_queue and upd_back; depends on upd_pkg.
//
// The decoder takes one encoded byte per transfer and returns decoded bytes
// in order, one per transfer: "%" with two hex digits becomes that byte, "+"
// becomes a space, and a broken escape is passed through literally. Ordinary
// bytes and valid escapes sustain one input byte per cycle while the output
// accepts every byte; a byte that completes a broken escape yields one to
// three output bytes, and once the two-group queue between the front and back
// ends has filled, input waits while the extra output bytes are sent. Output
// bytes pass through a queue entry and then a registered output stage.
module url_percent_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic            push_valid, push_ready;
  upd_pkg::group_t push_grp;
  logic            head_valid, pop;
  upd_pkg::group_t head;

  upd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .push_valid (push_valid),
    .push_grp   (push_grp),
    .push_ready (push_ready)
  );

  upd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_grp   (push_grp),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  upd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_last   (out_last)
  );

endmodule

// ===== src/upd_front.sv =====
// Front end of the URL percent decoder: tracks the escape state and turns each
// input byte into a group of zero to three output bytes. Depends on upd_pkg.
module upd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  output logic            push_valid,
  output upd_pkg::group_t push_grp,
  input  logic            push_ready
);

  upd_pkg::phase_t phase, phase_next;
  logic [7:0] held, held_next;
  upd_pkg::group_t grp;
  logic accept;
  logic b_hex, plain_emit, plain_escape;
  logic [7:0] plain_byte;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    b_hex        = upd_pkg::is_hex(in_byte);
    plain_escape = (in_byte == upd_pkg::CH_PERCENT) && !in_last;
    plain_emit   = !plain_escape;
    plain_byte   = (in_byte == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE : in_byte;
    grp          = '0;
    grp.last     = in_last;
    held_next    = held;
    phase_next   = upd_pkg::PH_IDLE;
    unique case (phase)
      upd_pkg::PH_PCT: begin
        if (b_hex) begin
          if (in_last) begin
            grp.data[0] = upd_pkg::CH_PERCENT;
            grp.data[1] = in_byte;
            grp.cnt     = 2'd2;
          end else begin
            held_next  = in_byte;
            phase_next = upd_pkg::PH_DIGIT;
          end
        end else begin
          grp.data[0] = upd_pkg::CH_PERCENT;
          grp.data[1] = plain_byte;
          grp.cnt     = plain_emit ? 2'd2 : 2'd1;
          phase_next  = plain_escape ? upd_pkg::PH_PCT : upd_pkg::PH_IDLE;
        end
      end
      upd_pkg::PH_DIGIT: begin
        if (b_hex) begin
          grp.data[0] = {upd_pkg::hex_val(held), upd_pkg::hex_val(in_byte)};
          grp.cnt     = 2'd1;
        end else begin
          grp.data[0] = upd_pkg::CH_PERCENT;
          grp.data[1] = held;
          grp.data[2] = plain_byte;
          grp.cnt     = plain_emit ? 2'd3 : 2'd2;
          phase_next  = plain_escape ? upd_pkg::PH_PCT : upd_pkg::PH_IDLE;
        end
      end
      default: begin
        grp.data[0] = plain_byte;
        grp.cnt     = plain_emit ? 2'd1 : 2'd0;
        phase_next  = plain_escape ? upd_pkg::PH_PCT : upd_pkg::PH_IDLE;
      end
    endcase
  end

  assign push_valid = accept && (grp.cnt != 2'd0);
  assign push_grp   = grp;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= upd_pkg::PH_IDLE;
      held  <= '0;
    end else if (accept) begin
      phase <= phase_next;
      held  <= held_next;
    end
  end

  // The end of a string always leaves the decoder with no escape pending.
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && in_last |=> phase == upd_pkg::PH_IDLE)
    else $error("escape still pending after last byte");

  // A last byte always produces at least one output byte.
  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    accept && in_last |-> push_valid)
    else $error("last byte produced no output");

endmodule

// ===== src/upd_queue.sv =====
// Short group queue between the front and back ends of the decoder.
// Depends on upd_pkg for the group type and queue depth.
module upd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  upd_pkg::group_t push_grp,
  output logic            head_valid,
  output upd_pkg::group_t head,
  input  logic            pop
);

  upd_pkg::group_t mem [upd_pkg::QDEPTH];
  logic [upd_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [upd_pkg::QCNT_W-1:0] count;
  logic push, pop_ok;

  assign push_ready = (count != upd_pkg::QCNT_W'(upd_pkg::QDEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop_ok     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= upd_pkg::QPTR_W'(wr_ptr + 1'b1);
      end
      if (pop_ok) begin
        rd_ptr <= upd_pkg::QPTR_W'(rd_ptr + 1'b1);
      end
      unique case ({push, pop_ok})
        2'b10:   count <= upd_pkg::QCNT_W'(count + 1'b1);
        2'b01:   count <= upd_pkg::QCNT_W'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

  // The back end never pops an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

// ===== src/upd_back.sv =====
// Back end of the URL percent decoder: serializes each queued group into
// single output bytes through a registered output stage. Depends on upd_pkg.
module upd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  upd_pkg::group_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  logic [1:0] idx;
  logic load, at_end;

  assign load   = !out_valid || out_ready;
  assign at_end = (idx == 2'(head.cnt - 2'd1));
  assign pop    = load && head_valid && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        idx <= at_end ? 2'd0 : 2'(idx + 2'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_byte <= head.data[idx];
      out_last <= head.last && at_end;
    end
  end

  // The byte index stays inside the group being sent.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (idx < head.cnt))
    else $error("byte index past end of group");

endmodule
